### hdl/can_frame_signal_range_validator_top_defines.svh
// assertion macros for the range validator
`ifndef CAN_FRAME_SIGNAL_RANGE_VALIDATOR_TOP_DEFINES_SVH
`define CAN_FRAME_SIGNAL_RANGE_VALIDATOR_TOP_DEFINES_SVH
// property checked on every clock edge outside reset
`define CFV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// property checked also during reset
`define CFV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

### hdl/cfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_pkg
// shared types and constants of the can frame signal range validator
// ----------------------------------------------------------------------------
package cfv_pkg;
    localparam int MESSAGE_ENTRIES   = 64;
    localparam int SIGNALS_PER_ENTRY = 16;
    localparam int EW = $clog2(MESSAGE_ENTRIES);
    localparam int SW = $clog2(SIGNALS_PER_ENTRY);
    localparam int SIG_TOTAL = MESSAGE_ENTRIES * SIGNALS_PER_ENTRY;
    localparam int TW = $clog2(SIG_TOTAL);
    // entry word: id, length, skip, count
    localparam int ENT_W = 29 + 4 + 1 + 5;
    // descriptor word: start, length, order, low, high
    localparam int DSC_W = 6 + 7 + 1 + 64 + 64;

    localparam logic [1:0] ACT_WR_ENTRY  = 2'd0;
    localparam logic [1:0] ACT_WR_SIGNAL = 2'd1;
    localparam logic [1:0] ACT_CHECK     = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    localparam logic [1:0] V_PASS    = 2'd0;
    localparam logic [1:0] V_UNKNOWN = 2'd1;
    localparam logic [1:0] V_LENGTH  = 2'd2;
    localparam logic [1:0] V_RANGE   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  entry_index;
        logic [3:0]  signal_index;
        logic [28:0] can_id;
        logic [3:0]  dlc;
        logic [63:0] data_word;
        logic [63:0] high_limit;
        logic        skip_check;
        logic [4:0]  signal_count;
        logic [5:0]  sig_offset;
        logic [6:0]  sig_bits;
        logic        little_endian;
    } t_in_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] failing_signal;
        logic       attack_flag;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic          load;      // capture input item
        logic          ent_wr;
        logic          dsc_wr;
        logic          ent_rd;    // read entry at scan index
        logic [EW-1:0] ent_addr;
        logic          match_ld;  // latch entry read data as matched
        logic          dsc_rd;
        logic [SW-1:0] sig_idx;
        logic          eval;      // evaluate descriptor read data
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       wr_ok;     // write slot in range
        logic       id_hit;    // entry read data matches id
        logic       len_ok;
        logic       no_sig;    // skip or count zero
        logic [4:0] count;     // saturated
        logic       sig_fail;  // evaluated signal failed
    } t_sts;
endpackage

### hdl/cfv_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_stream_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface cfv_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/cfv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module cfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

### hdl/cfv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_datapath
// item register, entry and descriptor tables, signal extraction and compare
// ----------------------------------------------------------------------------
module cfv_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfv_pkg::t_in_item i_item,
    input  cfv_pkg::t_cmd     i_cmd,
    output cfv_pkg::t_sts     o_sts
);
    cfv_pkg::t_in_item r_item;
    logic [cfv_pkg::MESSAGE_ENTRIES-1:0] r_valid;
    logic [cfv_pkg::EW-1:0] r_match;
    logic [cfv_pkg::ENT_W-1:0] r_ment;
    logic [cfv_pkg::EW-1:0] r_rd_addr;
    logic r_fail;
    logic [63:0] r_payload;
    logic [6:0] r_pbits;

    logic [cfv_pkg::ENT_W-1:0] ent_wdata, ent_rdata;
    logic [cfv_pkg::DSC_W-1:0] dsc_wdata, dsc_rdata;
    logic [cfv_pkg::EW-1:0] ent_addr;
    logic [cfv_pkg::TW-1:0] dsc_addr;
    logic [cfv_pkg::EW-1:0] wr_e;

    assign wr_e = r_item.entry_index[cfv_pkg::EW-1:0];
    assign ent_wdata = {r_item.can_id, r_item.dlc, r_item.skip_check, r_item.signal_count};
    assign dsc_wdata = {r_item.sig_offset, r_item.sig_bits, r_item.little_endian,
                        r_item.data_word, r_item.high_limit};
    assign ent_addr = i_cmd.ent_wr ? wr_e : i_cmd.ent_addr;
    assign dsc_addr = i_cmd.dsc_wr
        ? {wr_e, r_item.signal_index[cfv_pkg::SW-1:0]}
        : {r_match, i_cmd.sig_idx};

    cfv_ram #(.WIDTH(cfv_pkg::ENT_W), .DEPTH(cfv_pkg::MESSAGE_ENTRIES)) u_ent (
        .i_clk(i_clk), .i_we(i_cmd.ent_wr), .i_addr(ent_addr),
        .i_wdata(ent_wdata), .o_rdata(ent_rdata));
    cfv_ram #(.WIDTH(cfv_pkg::DSC_W), .DEPTH(cfv_pkg::SIG_TOTAL)) u_dsc (
        .i_clk(i_clk), .i_we(i_cmd.dsc_wr), .i_addr(dsc_addr),
        .i_wdata(dsc_wdata), .o_rdata(dsc_rdata));

    // signal extraction from descriptor read data
    logic [5:0]  d_s;
    logic [6:0]  d_l;
    logic        d_o;
    logic [63:0] d_lo, d_hi;
    logic [7:0]  se;
    logic [3:0]  n;
    logic [6:0]  lo_b, lo_l;
    logic [63:0] bytes, rev, v, lmask, nmask;
    logic        out_of;

    assign {d_s, d_l, d_o, d_lo, d_hi} = dsc_rdata;

    always_comb begin
        se = {2'b0, d_s} + {1'b0, d_l};
        n = 4'(se[7:3] - {2'b0, d_s[5:3]});
        out_of = se > {1'b0, r_pbits};
        lmask = (d_l >= 7'd64) ? '1 : ((64'd1 << d_l[5:0]) - 64'd1);
        nmask = (n >= 4'd8) ? '1 : ((64'd1 << {n[2:0], 3'b0}) - 64'd1);
        lo_b = 7'(r_pbits - {1'b0, d_s[5:3], 3'b0} - {n[2:0], 3'b0});
        if (n >= 4'd8) lo_b = 7'(r_pbits - {1'b0, d_s[5:3], 3'b0} - 7'd64);
        lo_l = 7'(r_pbits - {1'b0, d_s} - d_l);
        bytes = (r_payload >> lo_b[5:0]) & nmask;
        rev = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n)
                rev = rev | (64'(bytes[8*i +: 8]) << (7'(8) * (7'(n) - 7'd1 - 7'(i))));
        end
        if (d_o && n > 4'd1)
            v = (rev >> d_s[2:0]) & lmask;
        else
            v = (r_payload >> lo_l[5:0]) & lmask;
    end

    logic [3:0] e_dlc;
    logic       e_skip;
    logic [4:0] e_cnt;
    logic [28:0] e_id;
    assign {e_id, e_dlc, e_skip, e_cnt} = r_ment;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.ent_wr) begin
            r_valid[wr_e] <= 1'b1;
        end
        if (i_cmd.load) begin
            r_item <= i_item;
            r_pbits <= (i_item.dlc > 4'd8) ? 7'd64 : {i_item.dlc[3:0], 3'b0};
        end
        if (i_cmd.load) begin
            r_payload <= (i_item.dlc >= 4'd8) ? i_item.data_word
                : (i_item.data_word & ((64'd1 << {i_item.dlc[2:0], 3'b0}) - 64'd1));
        end
        r_rd_addr <= i_cmd.ent_addr;
        if (i_cmd.match_ld) begin
            r_ment <= ent_rdata;
            r_match <= r_rd_addr;
        end
        if (i_cmd.eval) begin
            r_fail <= out_of || (v < d_lo) || (v > d_hi);
        end
    end

    logic [28:0] rd_id;
    assign rd_id = ent_rdata[cfv_pkg::ENT_W-1 -: 29];

    always_comb begin
        o_sts.action = r_item.action;
        o_sts.wr_ok = ({1'b0, r_item.entry_index} < 7'(cfv_pkg::MESSAGE_ENTRIES))
            && (r_item.action != cfv_pkg::ACT_WR_SIGNAL
                || {1'b0, r_item.signal_index} < 5'(cfv_pkg::SIGNALS_PER_ENTRY));
        o_sts.id_hit = r_valid[r_rd_addr] && rd_id == r_item.can_id;
        o_sts.len_ok = e_dlc == r_item.dlc;
        o_sts.no_sig = e_skip || e_cnt == 5'd0;
        o_sts.count = (e_cnt > 5'(cfv_pkg::SIGNALS_PER_ENTRY))
            ? 5'(cfv_pkg::SIGNALS_PER_ENTRY) : e_cnt;
        o_sts.sig_fail = r_fail;
    end
    // entry read addr register is used only with the search
    logic unused;
    assign unused = i_cmd.ent_rd | i_cmd.dsc_rd | (^e_id);
endmodule

### hdl/cfv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_ctrl
// sequencer: id search, length test, one signal per pass, result hold
// ----------------------------------------------------------------------------
module cfv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cfv_pkg::t_out_item o_out,
    output cfv_pkg::t_cmd      o_cmd,
    input  cfv_pkg::t_sts      i_sts
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SEARCH, S_MATCH, S_SIGRD, S_EVAL, S_TEST, S_DONE
    } t_state;

    t_state r_state;
    logic [cfv_pkg::EW:0] r_scan;
    logic [cfv_pkg::SW:0] r_sig;
    cfv_pkg::t_out_item r_out;
    logic r_ovalid;

    assign o_in_ready = r_state == S_IDLE && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = i_in_valid && o_in_ready;
        o_cmd.ent_addr = r_scan[cfv_pkg::EW-1:0];
        o_cmd.sig_idx = r_sig[cfv_pkg::SW-1:0];
        o_cmd.ent_wr = r_state == S_DECODE && i_sts.action == cfv_pkg::ACT_WR_ENTRY
            && i_sts.wr_ok;
        o_cmd.dsc_wr = r_state == S_DECODE && i_sts.action == cfv_pkg::ACT_WR_SIGNAL
            && i_sts.wr_ok;
        o_cmd.ent_rd = r_state == S_SEARCH;
        o_cmd.match_ld = r_state == S_MATCH && i_sts.id_hit;
        o_cmd.dsc_rd = r_state == S_SIGRD;
        o_cmd.eval = r_state == S_EVAL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_scan <= '0;
            r_sig <= '0;
            r_out <= '0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_out <= '0;
                    r_scan <= '0;
                    r_sig <= '0;
                    if (i_sts.action == cfv_pkg::ACT_CHECK) r_state <= S_SEARCH;
                    else r_state <= S_DONE;
                end
                // read issued at r_scan, compared next cycle
                S_SEARCH: r_state <= S_MATCH;
                S_MATCH: begin
                    if (i_sts.id_hit) begin
                        r_state <= S_TEST;
                    end else if (r_scan == (cfv_pkg::EW+1)'(cfv_pkg::MESSAGE_ENTRIES - 1)) begin
                        r_out <= '{verdict: cfv_pkg::V_UNKNOWN, failing_signal: '0,
                                   attack_flag: 1'b1};
                        r_state <= S_DONE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                        r_state <= S_SEARCH;
                    end
                end
                // fail flag of the previous signal is tested here after each eval
                S_TEST: begin
                    if (r_sig != '0 && i_sts.sig_fail) begin
                        r_out <= '{verdict: cfv_pkg::V_RANGE,
                                   failing_signal: 4'(r_sig - 1'b1), attack_flag: 1'b1};
                        r_state <= S_DONE;
                    end else if (!i_sts.len_ok) begin
                        r_out <= '{verdict: cfv_pkg::V_LENGTH, failing_signal: '0,
                                   attack_flag: 1'b1};
                        r_state <= S_DONE;
                    end else if (i_sts.no_sig) begin
                        r_state <= S_DONE;
                    end else if (r_sig == (cfv_pkg::SW+1)'(i_sts.count)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SIGRD;
                    end
                end
                S_SIGRD: r_state <= S_EVAL;
                S_EVAL: begin
                    r_sig <= r_sig + 1'b1;
                    r_state <= S_TEST;
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/can_frame_signal_range_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_signal_range_validator_top
// can id table lookup with length and signal range checks
// ----------------------------------------------------------------------------
// One item at a time. A check scans the entry table linearly, reading each
// entry from the registered ram and then comparing it (S_SEARCH, S_MATCH),
// then tests, reads and evaluates each signal through the descriptor ram
// (S_TEST, S_SIGRD, S_EVAL). The result is held in an output register until
// taken; a new item is taken once it is.
`include "can_frame_signal_range_validator_top_defines.svh"
module can_frame_signal_range_validator_top (
    input logic i_clk,
    input logic i_rst_n,
    cfv_stream_if.sink   i_in,
    cfv_stream_if.source o_out
);
    cfv_pkg::t_cmd cmd;
    cfv_pkg::t_sts sts;

    cfv_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in.data),
        .i_cmd(cmd), .o_sts(sts));

    cfv_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_out(o_out.data), .o_cmd(cmd), .i_sts(sts));

    `CFV_ASSERT(a_no_accept_busy, o_out.valid |-> !i_in.ready, "accept while result pending")
    `CFV_ASSERT(a_attack, o_out.valid |-> (o_out.data.attack_flag == (o_out.data.verdict != cfv_pkg::V_PASS)), "attack flag mismatch")
    `CFV_ASSERT(a_one_write, !(cmd.ent_wr && cmd.dsc_wr), "two writes at once")
endmodule
